### sv/pip_pkg.sv
`default_nettype none
package pip_pkg;

	localparam int MaxVertices = 64;
	localparam int IdxW        = 6;
	localparam int CntW        = 7;
	localparam int LatW        = 30;
	localparam int LngW        = 31;
	localparam int NLngW       = 32;
	localparam int PLatW       = 31;
	localparam int PLngW       = 33;
	localparam int DLngW       = 33;
	localparam int DLatW       = 31;
	localparam int ProdW       = 64;
	localparam int QuoW        = 34;
	localparam int SumW        = 35;
	localparam int StepW       = 6;

	localparam logic [NLngW-1:0] TWO_PI_Q28 = 32'd1686629713;

	localparam logic OP_VERTEX = 1'b0;
	localparam logic OP_POINT  = 1'b1;

	localparam logic REG_VERTEX_COUNT  = 1'b0;
	localparam logic REG_TRANSMERIDIAN = 1'b1;

	typedef struct packed {
		logic [LatW-1:0] lat;
		logic [LngW-1:0] lng;
	} vertex_t;

	typedef struct packed {
		logic signed [DLngW-1:0] dlng;
		logic [DLatW-1:0]        dlat;
		logic [DLatW-1:0]        den;
	} edge_req_t;

	typedef enum logic [2:0] {
		S_IDLE, S_LD0, S_CAP0, S_RD, S_EDGE, S_CALC
	} walk_state_t;

	typedef enum logic [1:0] {
		U_IDLE, U_MUL, U_DIV, U_DONE
	} unit_state_t;

endpackage
`default_nettype wire

### sv/pip_vram.sv
`default_nettype none
module pip_vram (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [pip_pkg::IdxW-1:0] waddr,
	input  wire pip_pkg::vertex_t         wdata,
	input  wire logic                     re,
	input  wire logic [pip_pkg::IdxW-1:0] raddr,
	output pip_pkg::vertex_t              rdata
);
	pip_pkg::vertex_t mem [pip_pkg::MaxVertices];
	pip_pkg::vertex_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

### sv/pip_edge_unit.sv
`default_nettype none
module pip_edge_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire pip_pkg::edge_req_t                req,
	output logic                                   done,
	output logic signed [pip_pkg::QuoW-1:0]        quo
);
	pip_pkg::unit_state_t state_q, state_d;
	logic [pip_pkg::StepW-1:0]     cnt_q;
	logic [pip_pkg::DLngW-1:0]     mag_q;
	logic                          neg_q;
	logic [pip_pkg::DLatW-1:0]     dlat_q;
	logic [pip_pkg::DLatW-1:0]     den_q;
	logic [pip_pkg::ProdW-1:0]     prod_q;
	logic [pip_pkg::DLngW-1:0]     quo_q;
	logic [pip_pkg::ProdW-1:0]     trial;

	assign trial = pip_pkg::ProdW'(den_q) << cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pip_pkg::U_IDLE: if (start) state_d = pip_pkg::U_MUL;
			pip_pkg::U_MUL:  if (cnt_q == pip_pkg::StepW'(pip_pkg::DLatW - 1))
				state_d = pip_pkg::U_DIV;
			pip_pkg::U_DIV:  if (cnt_q == '0) state_d = pip_pkg::U_DONE;
			pip_pkg::U_DONE: state_d = pip_pkg::U_IDLE;
			default:         state_d = pip_pkg::U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pip_pkg::U_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pip_pkg::U_IDLE: begin
				if (start) begin
					mag_q  <= req.dlng[pip_pkg::DLngW-1] ? pip_pkg::DLngW'(-req.dlng)
					                                     : pip_pkg::DLngW'(req.dlng);
					neg_q  <= req.dlng[pip_pkg::DLngW-1];
					dlat_q <= req.dlat;
					den_q  <= req.den;
					prod_q <= '0;
					cnt_q  <= '0;
				end
			end
			pip_pkg::U_MUL: begin
				if (dlat_q[cnt_q[4:0]]) begin
					prod_q <= prod_q + (pip_pkg::ProdW'(mag_q) << cnt_q);
				end
				if (cnt_q == pip_pkg::StepW'(pip_pkg::DLatW - 1)) begin
					cnt_q <= pip_pkg::StepW'(pip_pkg::DLngW - 1);
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			pip_pkg::U_DIV: begin
				if (prod_q >= trial) begin
					prod_q       <= prod_q - trial;
					quo_q[cnt_q] <= 1'b1;
				end else begin
					quo_q[cnt_q] <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		done = (state_q == pip_pkg::U_DONE);
		quo  = neg_q ? -pip_pkg::QuoW'(signed'({1'b0, quo_q}))
		             :  pip_pkg::QuoW'(signed'({1'b0, quo_q}));
	end
endmodule
`default_nettype wire

### sv/point_in_polygon_ray_cast_unit.sv
`default_nettype none
// A vertex word is written to the store when accepted. A point word loads vertex 0
// and walks the edges; one that reaches the crossing math runs the 31-step shift-add
// multiply, 33-step restoring divide (pip_edge_unit). Empty ring: result next cycle.
// Throughput: one word at a time; busy is high for the whole walk.
// Reset: arst_n clears control and result; datapath regs and vertex store are not reset.
// The result is a single-cycle done strobe; the receiver cannot stall.
module point_in_polygon_ray_cast_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        operation,
	input  wire logic [5:0]  vertex_index,
	input  wire logic signed [29:0] vertex_lat,
	input  wire logic signed [30:0] vertex_lng,
	input  wire logic signed [29:0] point_lat,
	input  wire logic signed [30:0] point_lng,
	output logic             done,
	output logic             inside_res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	pip_pkg::walk_state_t state_q, state_d;
	logic [pip_pkg::CntW-1:0] vcount_q;
	logic                     tm_q;
	logic [pip_pkg::CntW-1:0] n;
	logic [pip_pkg::CntW-1:0] edge_q;
	logic [pip_pkg::CntW-1:0] edge_inc;
	logic [pip_pkg::CntW-1:0] nxt_idx;
	logic                     last_edge;
	logic                     accept;
	logic                     cfg_wr;

	logic signed [pip_pkg::PLatW-1:0]  plat_q;
	logic signed [pip_pkg::PLngW-1:0]  plng_q;
	logic                              inside_q;
	logic                              done_q;
	logic                              res_q;
	pip_pkg::vertex_t                  prev_q;
	logic signed [pip_pkg::NLngW-1:0]  alng_q;

	logic                    mem_re;
	logic [pip_pkg::IdxW-1:0] mem_raddr;
	pip_pkg::vertex_t        mem_rdata;
	pip_pkg::vertex_t        wvert;

	logic signed [pip_pkg::LatW-1:0]  alat, blat;
	logic signed [pip_pkg::LngW-1:0]  alng_r, blng_r;
	logic signed [pip_pkg::NLngW-1:0] alng_n, blng_n;
	logic signed [pip_pkg::PLatW-1:0] plat_new;
	logic signed [pip_pkg::PLngW-1:0] plng_new;
	logic signed [pip_pkg::PLatW-1:0] den_s;
	logic                             skip;
	pip_pkg::edge_req_t               req;
	logic                             u_start;
	logic                             u_done;
	logic signed [pip_pkg::QuoW-1:0]  u_quo;
	logic signed [pip_pkg::SumW-1:0]  tsum, tnorm;
	logic signed [pip_pkg::SumW-1:0]  two_pi_w;
	logic signed [pip_pkg::PLngW-1:0] plng_in;

	function automatic logic signed [pip_pkg::NLngW-1:0] norm_lng(
		input logic signed [pip_pkg::LngW-1:0] v, input logic tm);
		logic signed [pip_pkg::NLngW-1:0] w;
		w = pip_pkg::NLngW'(v);
		if (tm && v < 0) begin
			w = w + signed'(pip_pkg::TWO_PI_Q28);
		end
		return w;
	endfunction

	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign n = (vcount_q > pip_pkg::CntW'(pip_pkg::MaxVertices))
	           ? pip_pkg::CntW'(pip_pkg::MaxVertices) : vcount_q;
	assign edge_inc  = edge_q + 1'b1;
	assign last_edge = (edge_inc == n);
	assign nxt_idx   = last_edge ? '0 : edge_inc;

	always_comb begin
		unique case (paddr[2])
			pip_pkg::REG_VERTEX_COUNT:  prdata = 32'(vcount_q);
			pip_pkg::REG_TRANSMERIDIAN: prdata = 32'(tm_q);
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			tm_q     <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				pip_pkg::REG_VERTEX_COUNT:  vcount_q <= pwdata[pip_pkg::CntW-1:0];
				pip_pkg::REG_TRANSMERIDIAN: tm_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign wvert = '{lat: vertex_lat, lng: vertex_lng};

	pip_vram u_vram (
		.clk   (clk),
		.we    (accept && operation == pip_pkg::OP_VERTEX),
		.waddr (vertex_index),
		.wdata (wvert),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// edge setup: lower endpoint first
	always_comb begin
		if (signed'(prev_q.lat) > signed'(mem_rdata.lat)) begin
			alat = signed'(mem_rdata.lat); alng_r = signed'(mem_rdata.lng);
			blat = signed'(prev_q.lat);    blng_r = signed'(prev_q.lng);
		end else begin
			alat = signed'(prev_q.lat);    alng_r = signed'(prev_q.lng);
			blat = signed'(mem_rdata.lat); blng_r = signed'(mem_rdata.lng);
		end
		alng_n = norm_lng(alng_r, tm_q);
		blng_n = norm_lng(blng_r, tm_q);
		plat_new = plat_q;
		if (plat_q == pip_pkg::PLatW'(alat) || plat_q == pip_pkg::PLatW'(blat)) begin
			plat_new = plat_q + 1'b1;
		end
		den_s = pip_pkg::PLatW'(blat) - pip_pkg::PLatW'(alat);
		skip  = (plat_new < pip_pkg::PLatW'(alat)) || (plat_new > pip_pkg::PLatW'(blat))
		        || (den_s == '0);
		plng_new = plng_q;
		if (!skip && (pip_pkg::PLngW'(alng_n) == plng_q
		              || pip_pkg::PLngW'(blng_n) == plng_q)) begin
			plng_new = plng_q - 1'b1;
		end
		req.dlng = pip_pkg::DLngW'(blng_n) - pip_pkg::DLngW'(alng_n);
		req.dlat = pip_pkg::DLatW'(plat_new - pip_pkg::PLatW'(alat));
		req.den  = pip_pkg::DLatW'(den_s);
	end

	assign u_start = (state_q == pip_pkg::S_EDGE) && !skip;

	pip_edge_unit u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (u_start),
		.req    (req),
		.done   (u_done),
		.quo    (u_quo)
	);

	assign two_pi_w = pip_pkg::SumW'(signed'({1'b0, pip_pkg::TWO_PI_Q28}));
	always_comb begin
		tsum  = pip_pkg::SumW'(alng_q) + pip_pkg::SumW'(u_quo);
		tnorm = (tm_q && tsum < 0) ? tsum + two_pi_w : tsum;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pip_pkg::S_IDLE:
				if (accept && operation == pip_pkg::OP_POINT && n != '0)
					state_d = pip_pkg::S_LD0;
			pip_pkg::S_LD0:  state_d = pip_pkg::S_CAP0;
			pip_pkg::S_CAP0: state_d = pip_pkg::S_EDGE;
			pip_pkg::S_RD:   state_d = pip_pkg::S_EDGE;
			pip_pkg::S_EDGE: begin
				if (!skip) state_d = pip_pkg::S_CALC;
				else if (last_edge) state_d = pip_pkg::S_IDLE;
				else state_d = pip_pkg::S_RD;
			end
			pip_pkg::S_CALC: begin
				if (u_done) state_d = last_edge ? pip_pkg::S_IDLE : pip_pkg::S_RD;
			end
			default: state_d = pip_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			pip_pkg::S_LD0: begin
				mem_re = 1'b1;
			end
			pip_pkg::S_CAP0, pip_pkg::S_RD: begin
				mem_re    = 1'b1;
				mem_raddr = nxt_idx[pip_pkg::IdxW-1:0];
			end
			default: ;
		endcase
	end

	assign plng_in = pip_pkg::PLngW'(norm_lng(point_lng, tm_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pip_pkg::S_IDLE;
			edge_q   <= '0;
			inside_q <= 1'b0;
			done_q   <= 1'b0;
			res_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				pip_pkg::S_IDLE: begin
					if (accept && operation == pip_pkg::OP_POINT) begin
						edge_q   <= '0;
						inside_q <= 1'b0;
						if (n == '0) begin
							done_q <= 1'b1;
							res_q  <= 1'b0;
						end
					end
				end
				pip_pkg::S_EDGE: begin
					if (skip) begin
						if (last_edge) begin
							done_q <= 1'b1;
							res_q  <= inside_q;
						end else begin
							edge_q <= edge_inc;
						end
					end
				end
				pip_pkg::S_CALC: begin
					if (u_done) begin
						if (last_edge) begin
							done_q <= 1'b1;
							res_q  <= inside_q ^ (tnorm > pip_pkg::SumW'(plng_q));
						end else begin
							inside_q <= inside_q ^ (tnorm > pip_pkg::SumW'(plng_q));
							edge_q   <= edge_inc;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pip_pkg::S_IDLE: begin
				plat_q <= pip_pkg::PLatW'(point_lat);
				plng_q <= plng_in;
			end
			pip_pkg::S_CAP0: prev_q <= mem_rdata;
			pip_pkg::S_EDGE: begin
				prev_q <= mem_rdata;
				plat_q <= plat_new;
				plng_q <= plng_new;
				alng_q <= alng_n;
			end
			default: ;
		endcase
	end

	assign busy       = (state_q != pip_pkg::S_IDLE);
	assign done       = done_q;
	assign inside_res = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while walk still running");
	a_point_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == pip_pkg::OP_POINT |=> busy || done)
		else $error("point word dropped");
	a_unit_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> state_q == pip_pkg::S_CALC) else $error("edge unit out of step");
endmodule
`default_nettype wire

### tb/tb_point_in_polygon_ray_cast_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_point_in_polygon_ray_cast_unit;

	localparam longint LAT_MAX = 421657428;
	localparam longint LNG_MAX = 843314857;
	localparam longint TWO_PI = 1686629713;

	class inside_board;
		bit     pending[$];
		int     fails;
		int     checked;
		int     ones;

		function void note(bit want);
			pending.push_back(want);
		endfunction

		function void check(bit got);
			bit want;
			if (pending.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("%0t: unexpected result inside_res=%0b", $realtime, got);
			end else begin
				want = pending.pop_front();
				checked++;
				ones += want;
				if (want != got) begin
					fails++;
					if (fails <= 10)
						$display("%0t: inside_res mismatch: expected %0b, got %0b",
							$realtime, want, got);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        operation = pip_pkg::OP_VERTEX;
	logic [5:0]  vertex_index = '0;
	logic signed [29:0] vertex_lat = '0;
	logic signed [30:0] vertex_lng = '0;
	logic signed [29:0] point_lat = '0;
	logic signed [30:0] point_lng = '0;
	logic        done;
	logic        inside_res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	inside_board board = new();

	longint ring_lat[pip_pkg::MaxVertices];
	longint ring_lng[pip_pkg::MaxVertices];
	bit     slot_set[pip_pkg::MaxVertices];
	int     cfg_count;
	bit     cfg_tm;
	int     n_items;
	int     n_points;
	bit     allow_idle;
	longint box_lat, box_lng, box_span;

	point_in_polygon_ray_cast_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .vertex_index(vertex_index),
		.vertex_lat(vertex_lat), .vertex_lng(vertex_lng),
		.point_lat(point_lat), .point_lng(point_lng),
		.done(done), .inside_res(inside_res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		#200ms;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && done)
			board.check(inside_res);

	function automatic longint wrap_lng(longint v);
		return (cfg_tm && v < 0) ? v + TWO_PI : v;
	endfunction

	function automatic bit ray_parity(longint plat, longint plng);
		int     n;
		int     ib;
		longint alat, alng, blat, blng, t, num, den;
		bit     odd;
		n = (cfg_count > pip_pkg::MaxVertices) ? pip_pkg::MaxVertices : cfg_count;
		odd = 1'b0;
		if (n == 0)
			return 1'b0;
		plng = wrap_lng(plng);
		for (int e = 0; e < n; e++) begin
			ib = (e + 1 == n) ? 0 : e + 1;
			alat = ring_lat[e];
			alng = ring_lng[e];
			blat = ring_lat[ib];
			blng = ring_lng[ib];
			if (alat > blat) begin
				t = alat; alat = blat; blat = t;
				t = alng; alng = blng; blng = t;
			end
			alng = wrap_lng(alng);
			blng = wrap_lng(blng);
			if (plat == alat || plat == blat)
				plat += 1;
			if (plat < alat || plat > blat)
				continue;
			if (alng == plng || blng == plng)
				plng -= 1;
			den = blat - alat;
			if (den <= 0)
				continue;
			num = (blng - alng) * (plat - alat);
			t = wrap_lng(alng + num / den);
			if (t > plng)
				odd = ~odd;
		end
		return odd;
	endfunction

	function automatic longint pick(longint lo, longint hi);
		return longint'($urandom_range(32'(hi - lo))) + lo;
	endfunction

	function automatic longint clip(longint v, longint lim);
		return (v > lim) ? lim : ((v < -lim) ? -lim : v);
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance, or later if allow_idle adds an idle gap
	task automatic push_word(bit op, int idx, longint vlat, longint vlng,
			longint plat, longint plng);
		operation = op;
		vertex_index = 6'(idx);
		vertex_lat = 30'(vlat);
		vertex_lng = 31'(vlng);
		point_lat = 30'(plat);
		point_lng = 31'(plng);
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		if (op == pip_pkg::OP_VERTEX) begin
			ring_lat[idx] = vlat;
			ring_lng[idx] = vlng;
			slot_set[idx] = 1'b1;
		end else begin
			board.note(ray_parity(plat, plng));
			n_points++;
		end
		n_items++;
		@(negedge clk);
		if (allow_idle && $urandom_range(3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(12, 1)) @(negedge clk);
		end
	endtask

	task automatic drain();
		start = 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic reg_write(logic sel, int value);
		drain();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {sel, 2'b00};
		pwdata = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (sel == pip_pkg::REG_VERTEX_COUNT)
			cfg_count = value & 7'h7f;
		else
			cfg_tm = value[0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic put_vertex(int idx);
		longint lat, lng;
		if ($urandom_range(9) == 0) begin
			lat = pick(-LAT_MAX, LAT_MAX);
			lng = pick(-LNG_MAX, LNG_MAX);
		end else begin
			lat = clip(box_lat + pick(-box_span, box_span), LAT_MAX);
			lng = clip(box_lng + pick(-box_span, box_span), LNG_MAX);
		end
		push_word(pip_pkg::OP_VERTEX, idx, lat, lng, pick(-LAT_MAX, LAT_MAX),
			pick(-LNG_MAX, LNG_MAX));
	endtask

	task automatic put_point(int n);
		longint lat, lng;
		int     k;
		k = (n == 0) ? 0 : $urandom_range(n - 1);
		lat = clip(box_lat + pick(-box_span, box_span), LAT_MAX);
		lng = clip(box_lng + pick(-box_span, box_span), LNG_MAX);
		case ($urandom_range(7))
			0: lat = ring_lat[k];
			1: lng = ring_lng[k];
			2: begin
				lat = ring_lat[k];
				lng = ring_lng[k];
			end
			3: begin
				lat = pick(-LAT_MAX, LAT_MAX);
				lng = pick(-LNG_MAX, LNG_MAX);
			end
			default: ;
		endcase
		push_word(pip_pkg::OP_POINT, $urandom_range(63), pick(-LAT_MAX, LAT_MAX),
			pick(-LNG_MAX, LNG_MAX), lat, lng);
	endtask

	initial begin
		int n, cnt, pts;
		n_items = 0;
		n_points = 0;
		cfg_count = 0;
		cfg_tm = 1'b0;
		allow_idle = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, equal latitude/longitude nudges, flat edge, empty ring
		push_word(pip_pkg::OP_POINT, 63, LAT_MAX, LNG_MAX, 0, 0);
		reg_write(pip_pkg::REG_VERTEX_COUNT, 4);
		reg_write(pip_pkg::REG_TRANSMERIDIAN, 0);
		push_word(pip_pkg::OP_VERTEX, 0, -LAT_MAX, -LNG_MAX, LAT_MAX, LNG_MAX);
		push_word(pip_pkg::OP_VERTEX, 1, -LAT_MAX, LNG_MAX, -LAT_MAX, -LNG_MAX);
		push_word(pip_pkg::OP_VERTEX, 2, LAT_MAX, LNG_MAX, 0, 0);
		push_word(pip_pkg::OP_VERTEX, 3, LAT_MAX, -LNG_MAX, 0, 0);
		push_word(pip_pkg::OP_POINT, 0, 0, 0, 0, 0);
		push_word(pip_pkg::OP_POINT, 0, 0, 0, LAT_MAX, 0);
		push_word(pip_pkg::OP_POINT, 0, 0, 0, -LAT_MAX, -LNG_MAX);
		push_word(pip_pkg::OP_POINT, 0, 0, 0, 5, LNG_MAX);
		push_word(pip_pkg::OP_POINT, 0, 0, 0, -5, -LNG_MAX);
		push_word(pip_pkg::OP_POINT, 0, 0, 0, LAT_MAX, LNG_MAX);
		reg_write(pip_pkg::REG_TRANSMERIDIAN, 1);
		push_word(pip_pkg::OP_POINT, 0, 0, 0, 0, -LNG_MAX);
		push_word(pip_pkg::OP_POINT, 0, 0, 0, 100, LNG_MAX);
		push_word(pip_pkg::OP_POINT, 0, 0, 0, -LAT_MAX, -1);
		reg_write(pip_pkg::REG_VERTEX_COUNT, 0);
		push_word(pip_pkg::OP_POINT, 0, 0, 0, 3, 3);

		allow_idle = 1'b1;
		while (n_items < 650) begin
			if (n_items > 540)
				allow_idle = 1'b0;
			case ($urandom_range(11))
				0: cnt = 0;
				1: cnt = 64;
				2: cnt = 127;
				3: cnt = 3;
				default: cnt = $urandom_range(10, 3);
			endcase
			n = (cnt > pip_pkg::MaxVertices) ? pip_pkg::MaxVertices : cnt;
			reg_write(pip_pkg::REG_VERTEX_COUNT, cnt);
			reg_write(pip_pkg::REG_TRANSMERIDIAN, $urandom_range(1));
			box_span = longint'(1) << $urandom_range(28, 4);
			box_lat = pick(-LAT_MAX, LAT_MAX);
			box_lng = cfg_tm ? (($urandom_range(1) ? LNG_MAX : -LNG_MAX) - 0)
				: pick(-LNG_MAX, LNG_MAX);
			for (int i = 0; i < n; i++) begin
				put_vertex(i);
				if ($urandom_range(7) == 0)
					put_vertex($urandom_range(63));
			end
			for (int i = 0; i < pip_pkg::MaxVertices && i < n; i++)
				if (!slot_set[i])
					put_vertex(i);
			pts = (n > 16) ? 3 : $urandom_range(20, 5);
			for (int i = 0; i < pts; i++) begin
				if ($urandom_range(15) == 0)
					drain();
				put_point(n);
			end
		end

		start = 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d words sent, %0d point tests checked (%0d inside), ring sizes 0..64",
			n_items, board.checked, board.ones);
		$display("incl. count saturation, transmeridian wrap and vertex-coincident points");
		if (board.fails == 0 && board.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", board.fails);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
